// ----- hdl/interpolative_list_encoder_core_defines.svh -----
// ----------------------------------------------------------------------------
// Interpolative list encoder assertion macros
// Shared property forms for the checker of the encoder core.
// ----------------------------------------------------------------------------
`ifndef INTERPOLATIVE_LIST_ENCODER_CORE_DEFINES_SVH
`define INTERPOLATIVE_LIST_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ILE_ASSERT_NOW(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("encoder check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define ILE_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("encoder check failed");

`endif

// ----- hdl/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// Interpolative list encoder package
// Result codes, code modes and the records passed between the parts.
// ----------------------------------------------------------------------------
`default_nettype none
package ile_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_ORDER    = 2'd2;

	localparam logic [1:0] MODE_PLAIN  = 2'd0;
	localparam logic [1:0] MODE_LEFT   = 2'd1;
	localparam logic [1:0] MODE_CENTER = 2'd2;

	localparam logic [5:0] HEADER_WIDTH = 6'd32;

	// Widest count and value the parameters allow.
	localparam int CNT_MAX_W = 17;
	localparam int VAL_MAX_W = 32;

	typedef struct packed {
		logic [1:0]           status;
		logic [CNT_MAX_W-1:0] n;
		logic [VAL_MAX_W-1:0] fin;
	} job_t;

	typedef struct packed {
		logic [31:0] code_value;
		logic [5:0]  code_width;
		logic        is_header;
		logic [1:0]  status;
		logic        end_of_run;
	} res_t;

endpackage
`default_nettype wire

// ----- hdl/interpolative_list_encoder_core.sv -----
// ----------------------------------------------------------------------------
// Interpolative list encoder core
// Collects a strictly increasing list and emits its interpolative codewords.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Carries
//  input    in_valid / in_stall    value, last
//  result   out_valid / out_stall  code_value, code_width, is_header, status,
//                                  end_of_run
//  config   cfg_valid / cfg_ready  cfg_data (code mode)
//
// List elements are written to the list memory as they are accepted. After
// the element marked last, the back end walks the list: frame check, list
// memory read, bound and width and code build for each codeword, and a pop
// for each empty frame, in turn, as the list memory has a single read port.
// The input is stalled from the cycle after the last element until the final
// result of that list has been passed to the output register.
// Reset clears the counters, the job queue, the sequencer and the code mode.
// The output register lets the walk run one result ahead of a stalled sink.
`default_nettype none
module interpolative_list_encoder_core #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] value,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      code_value,
	output logic [5:0]       code_width,
	output logic             is_header,
	output logic [1:0]       status,
	output logic             end_of_run,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data
);
	localparam int AW = $clog2(MAX_ITEMS);

	logic                  accept;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	logic [AW-1:0]         rd_addr;
	logic [VALUE_BITS-1:0] rd_data;
	logic                  job_push;
	ile_pkg::job_t         push_job;
	ile_pkg::job_t         head_job;
	logic                  jobq_empty;
	logic                  job_pop;
	logic                  back_busy;
	logic [1:0]            mode_q;
	ile_pkg::res_t         res;

	// The list memory is shared, so a new list waits until the walk is done.
	assign in_stall  = !jobq_empty || back_busy;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= ile_pkg::MODE_PLAIN;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	ile_front #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.value    (value),
		.last     (last),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.job_push (job_push),
		.job      (push_job)
	);

	ile_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ITEMS)) u_list (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ile_jobq u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (push_job),
		.pop      (job_pop),
		.empty    (jobq_empty),
		.head     (head_job)
	);

	ile_back #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_mode (mode_q),
		.job_ready (!jobq_empty),
		.job       (head_job),
		.job_pop   (job_pop),
		.busy      (back_busy),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	assign code_value = res.code_value;
	assign code_width = res.code_width;
	assign is_header  = res.is_header;
	assign status     = res.status;
	assign end_of_run = res.end_of_run;
endmodule
`default_nettype wire

// ----- hdl/ile_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire

// ----- hdl/ile_front.sv -----
// ----------------------------------------------------------------------------
// Interpolative list encoder front end
// Stores list elements, checks order and capacity, issues one job per list.
// ----------------------------------------------------------------------------
`default_nettype none
module ile_front #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [31:0]                   value,
	input  wire logic                          last,
	output logic                               wr_en,
	output logic [$clog2(MAX_ITEMS)-1:0]       wr_addr,
	output logic [VALUE_BITS-1:0]              wr_data,
	output logic                               job_push,
	output ile_pkg::job_t                      job
);
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = $clog2(MAX_ITEMS);

	logic [CW-1:0]         count_q;
	logic [1:0]            err_q;
	logic [VALUE_BITS-1:0] prev_q;
	logic [VALUE_BITS-1:0] v;
	logic                  full;
	logic [1:0]            err_new;
	logic [CW-1:0]         count_new;

	assign v    = value[VALUE_BITS-1:0];
	assign full = (count_q == CW'(MAX_ITEMS));

	always_comb begin
		err_new   = err_q;
		count_new = count_q;
		if (full) begin
			err_new[0] = 1'b1;
		end else begin
			if (count_q != '0 && v <= prev_q) begin
				err_new[1] = 1'b1;
			end
			count_new = count_q + CW'(1);
		end
	end

	assign wr_en    = accept && !full;
	assign wr_addr  = count_q[AW-1:0];
	assign wr_data  = v;
	assign job_push = accept && last;

	always_comb begin
		job.n   = ile_pkg::CNT_MAX_W'(count_new);
		job.fin = ile_pkg::VAL_MAX_W'(v);
		priority if (err_new[0]) begin
			job.status = ile_pkg::ST_OVERFLOW;
		end else if (err_new[1]) begin
			job.status = ile_pkg::ST_ORDER;
		end else begin
			job.status = ile_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			err_q   <= '0;
		end else if (accept) begin
			if (last) begin
				count_q <= '0;
				err_q   <= '0;
			end else begin
				count_q <= count_new;
				err_q   <= err_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			prev_q <= v;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ile_jobq.sv -----
// ----------------------------------------------------------------------------
// Interpolative list encoder job queue
// Two-entry queue of list jobs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none
module ile_jobq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ile_pkg::job_t push_job,
	input  wire logic          pop,
	output logic               empty,
	output ile_pkg::job_t      head
);
	ile_pkg::job_t entry_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    fill_q;

	assign empty = (fill_q == 2'd0);
	assign head  = entry_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= 1'b0;
			rp_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= push_job;
		end
	end
endmodule
`default_nettype wire

// ----- hdl/ile_back.sv -----
// ----------------------------------------------------------------------------
// Interpolative list encoder back end
// Walks the list in pre-order with a frame stack and emits codewords.
// ----------------------------------------------------------------------------
`default_nettype none
module ile_back #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [1:0]                   code_mode,
	input  wire logic                         job_ready,
	input  wire ile_pkg::job_t                job,
	output logic                              job_pop,
	output logic                              busy,
	output logic [$clog2(MAX_ITEMS)-1:0]      rd_addr,
	input  wire logic [VALUE_BITS-1:0]        rd_data,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output ile_pkg::res_t                     out_res
);
	localparam int CW  = $clog2(MAX_ITEMS + 1);
	localparam int AW  = $clog2(MAX_ITEMS);
	localparam int LW  = VALUE_BITS + 1;
	localparam int UW  = VALUE_BITS + 2;
	localparam int BW  = $clog2(UW);
	localparam int SD  = AW + 3;
	localparam int SPW = $clog2(SD + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_NODE  = 7'b0000010,
		S_WAIT  = 7'b0000100,
		S_CALC  = 7'b0001000,
		S_CODE  = 7'b0010000,
		S_POP   = 7'b0100000,
		S_FLUSH = 7'b1000000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] base_q, cnt_q, h_q;
	logic [LW-1:0] lo_q, hi_q;
	logic [CW-1:0] stk_base_q [SD];
	logic [CW-1:0] stk_cnt_q  [SD];
	logic [LW-1:0] stk_lo_q   [SD];
	logic [LW-1:0] stk_hi_q   [SD];
	logic [SPW-1:0] sp_q;
	logic [VALUE_BITS-1:0] x_q;
	logic [UW-1:0] u_q, d_q;
	logic [BW-1:0] b_q;
	ile_pkg::res_t pend_q, out_q;
	logic          out_valid_q;

	logic          can_push;
	logic          dead;
	logic [CW:0]   idx;
	logic [CW-1:0] nm1, nm2, root_h;
	logic [BW-1:0] tb_u;
	logic [CW-1:0] cnt_r;
	logic [UW-1:0] pow, shorts, tsum, vcode, mask;
	logic [5:0]    wcode;
	logic signed [UW:0] c_s, c2_s, r2_s, lo2_s, hi2_s, d_s;

	assign can_push  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign busy      = (state_q != S_IDLE);
	assign job_pop   = (state_q == S_IDLE) && job_ready;

	assign idx  = (CW+1)'(base_q) + (CW+1)'(h_q);
	assign dead = (cnt_q == '0)
		|| (UW'(hi_q) + UW'(1) <= UW'(lo_q) + UW'(cnt_q))
		|| (h_q >= cnt_q)
		|| (idx >= (CW+1)'(MAX_ITEMS));
	assign rd_addr = idx[AW-1:0];

	// Root middle: half the next power of two of n-1.
	assign nm1 = CW'(job.n) - CW'(1);
	assign nm2 = nm1 - CW'(1);
	always_comb begin
		root_h = '0;
		for (int i = 0; i < CW; i++) begin
			if (nm2[i]) begin
				root_h = CW'(1) << i;
			end
		end
		if (nm1 < CW'(2)) begin
			root_h = '0;
		end
	end

	always_comb begin
		tb_u = '0;
		for (int i = 0; i < UW; i++) begin
			if (u_q[i]) begin
				tb_u = BW'(i);
			end
		end
	end

	assign cnt_r = cnt_q - h_q - CW'(1);

	// Codeword for d against bound u.
	always_comb begin
		pow    = UW'(1) << (b_q + BW'(1));
		shorts = pow - u_q - UW'(1);
		tsum   = d_q + shorts;
		c_s    = (UW+1)'(shorts);
		c2_s   = c_s >>> 1;
		r2_s   = (UW+1)'(u_q >> 1);
		lo2_s  = r2_s - c2_s - (UW+1)'(!u_q[0]);
		hi2_s  = r2_s + c2_s + (UW+1)'(1);
		d_s    = (UW+1)'(d_q);
		unique case (code_mode)
			ile_pkg::MODE_LEFT: begin
				if (d_q < shorts) begin
					wcode = 6'(b_q);
					vcode = d_q;
				end else begin
					wcode = 6'(b_q) + 6'd1;
					vcode = (UW'(tsum[0]) << b_q) | (tsum >> 1);
				end
			end
			ile_pkg::MODE_CENTER: begin
				wcode = 6'(b_q) + 6'((d_s <= lo2_s) || (d_s >= hi2_s));
				vcode = d_q;
			end
			default: begin
				wcode = 6'(b_q) + 6'd1;
				vcode = d_q;
			end
		endcase
		mask = (UW'(1) << wcode) - UW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (job_ready) begin
						sp_q    <= '0;
						state_q <= (job.status != ile_pkg::ST_OK || nm1 == '0)
							? S_FLUSH : S_NODE;
					end
				end
				S_NODE: state_q <= dead ? S_POP : S_WAIT;
				S_WAIT: begin
					state_q <= (UW'(rd_data) < UW'(lo_q) + UW'(h_q)) ? S_POP : S_CALC;
				end
				S_CALC: state_q <= S_CODE;
				S_CODE: begin
					if (can_push) begin
						out_valid_q <= 1'b1;
						sp_q        <= sp_q + SPW'(1);
						state_q     <= S_NODE;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_FLUSH;
					end else begin
						sp_q    <= sp_q - SPW'(1);
						state_q <= S_NODE;
					end
				end
				S_FLUSH: begin
					if (can_push) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				base_q <= '0;
				cnt_q  <= nm1;
				lo_q   <= '0;
				hi_q   <= LW'(job.fin[VALUE_BITS-1:0]);
				h_q    <= root_h;
				if (job.status != ile_pkg::ST_OK) begin
					pend_q <= '{code_value: '0, code_width: '0, is_header: 1'b0,
						status: job.status, end_of_run: 1'b0};
				end else begin
					pend_q <= '{code_value: 32'(job.fin[VALUE_BITS-1:0]),
						code_width: ile_pkg::HEADER_WIDTH, is_header: 1'b1,
						status: ile_pkg::ST_OK, end_of_run: 1'b0};
				end
			end
			S_WAIT: begin
				x_q <= rd_data;
				u_q <= UW'(hi_q) + UW'(1) - UW'(lo_q) - UW'(cnt_q);
				d_q <= UW'(rd_data) - UW'(lo_q) - UW'(h_q);
			end
			S_CALC: b_q <= tb_u;
			S_CODE: begin
				if (can_push) begin
					out_q  <= pend_q;
					pend_q <= '{code_value: 32'(vcode & mask), code_width: wcode,
						is_header: 1'b0, status: ile_pkg::ST_OK, end_of_run: 1'b0};
					stk_base_q[sp_q[$clog2(SD)-1:0]] <= base_q + h_q + CW'(1);
					stk_cnt_q[sp_q[$clog2(SD)-1:0]]  <= cnt_r;
					stk_lo_q[sp_q[$clog2(SD)-1:0]]   <= LW'(x_q) + LW'(1);
					stk_hi_q[sp_q[$clog2(SD)-1:0]]   <= hi_q;
					cnt_q <= h_q;
					hi_q  <= LW'(x_q) - LW'(1);
					h_q   <= h_q >> 1;
				end
			end
			S_POP: begin
				if (sp_q != '0) begin
					base_q <= stk_base_q[$clog2(SD)'(sp_q - SPW'(1))];
					cnt_q  <= stk_cnt_q[$clog2(SD)'(sp_q - SPW'(1))];
					lo_q   <= stk_lo_q[$clog2(SD)'(sp_q - SPW'(1))];
					hi_q   <= stk_hi_q[$clog2(SD)'(sp_q - SPW'(1))];
					h_q    <= stk_cnt_q[$clog2(SD)'(sp_q - SPW'(1))] >> 1;
				end
			end
			S_FLUSH: begin
				if (can_push) begin
					out_q <= '{code_value: pend_q.code_value,
						code_width: pend_q.code_width, is_header: pend_q.is_header,
						status: pend_q.status, end_of_run: 1'b1};
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- hdl/ile_checker.sv -----
// ----------------------------------------------------------------------------
// Interpolative list encoder checker
// Port-level properties of the result channel, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "interpolative_list_encoder_core_defines.svh"
module ile_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] code_value,
	input wire logic [5:0]  code_width,
	input wire logic        is_header,
	input wire logic [1:0]  status,
	input wire logic        end_of_run
);
	`ILE_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(code_value))
	`ILE_ASSERT_NOW(a_header, out_valid && is_header, status == ile_pkg::ST_OK && code_width == ile_pkg::HEADER_WIDTH)
	`ILE_ASSERT_NOW(a_error, out_valid && status != ile_pkg::ST_OK, end_of_run && code_width == 6'd0 && !is_header)
	`ILE_ASSERT_NOW(a_width, out_valid && !is_header, code_width <= 6'd32)
endmodule

bind interpolative_list_encoder_core ile_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.code_value (code_value),
	.code_width (code_width),
	.is_header  (is_header),
	.status     (status),
	.end_of_run (end_of_run)
);
`default_nettype wire
